// ----- design/ucdp_pkg.sv -----
`timescale 1ns / 1ps

package ucdp_pkg;

  // Default endpoint table depth and the widest counts the depth range needs
  localparam int MAX_ENDPOINTS_DEF = 16;
  localparam int CNT_W             = 6;   // holds a count up to 63
  localparam int IDX_W             = 5;   // holds an entry index up to 31
  localparam int TOT_W             = 5;   // endpoint_total field
  localparam int MPS_W             = 11;  // max packet field, mask 0x07FF

  // Descriptor type codes
  localparam logic [7:0] TYPE_INTERFACE    = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT     = 8'd5;
  localparam logic [7:0] TYPE_SS_COMPANION = 8'd48;

  // Minimum lengths of the descriptors that count
  localparam logic [7:0] LEN_INTERFACE = 8'd9;
  localparam logic [7:0] LEN_ENDPOINT  = 8'd7;
  localparam logic [7:0] LEN_COMPANION = 8'd6;

  // A run shorter than this gives an empty summary
  localparam logic [3:0] MIN_RUN_BYTES = 4'd9;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_WANT_CLASS    = 2'd0;
  localparam logic [1:0] CFG_WANT_SUBCLASS = 2'd1;
  localparam logic [1:0] CFG_WANT_PROTOCOL = 2'd2;

  localparam logic [7:0] WANT_CLASS_RST    = 8'd8;
  localparam logic [7:0] WANT_SUBCLASS_RST = 8'd6;
  localparam logic [7:0] WANT_PROTOCOL_RST = 8'd80;

  localparam logic RECORD_SUMMARY  = 1'b0;
  localparam logic RECORD_ENDPOINT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic             record_kind;
    logic             found;
    logic [7:0]       number_or_address;
    logic [7:0]       class_or_attributes;
    logic [7:0]       subclass_or_interval;
    logic [7:0]       iface_protocol;
    logic [TOT_W-1:0] endpoint_total;
    logic [MPS_W-1:0] max_packet;
    logic [7:0]       max_burst;
    logic             last_record;
  } out_item_t;

  typedef struct packed {
    logic [7:0] proto;
    logic [7:0] sub;
    logic [7:0] cls;
    logic [7:0] num;
  } iface_t;

  typedef struct packed {
    logic [7:0]       addr;
    logic [7:0]       attr;
    logic [7:0]       interval;
    logic [MPS_W-1:0] mps;
  } ep_data_t;

  // Endpoint store into the table
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    ep_data_t         data;
  } ep_wr_t;

  // Burst update from a companion descriptor
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       burst;
  } burst_wr_t;

  // One finished run handed from the parser to the emitter
  typedef struct packed {
    logic             found;
    iface_t           iface;
    logic [CNT_W-1:0] n;
    logic             bank;
  } run_t;

  typedef struct packed {
    logic       nonempty;
    logic [1:0] busy;     // table bank still owned by the emitter
  } q_status_t;

  typedef enum logic {
    BK_SUMMARY,
    BK_ENDPOINT
  } bk_state_t;

endpackage

// ----- design/usb_config_descriptor_parser_top.sv -----
`timescale 1ns / 1ps
// USB configuration descriptor parser.
// in_*  : one descriptor byte per item, final_byte marks the last byte of the
//         buffer. Taken when in_valid is high and in_stall is low.
// out_* : result items. A run gives a summary record, then one record per
//         stored endpoint; last_record marks the end. Taken when out_valid is
//         high and out_stall is low.
// cfg_* : writes want_class (0), want_subclass (1), want_protocol (2); any
//         other index is ignored. cfg_ready is always high. Write only while
//         idle.
// Throughput: one byte per cycle. The parser fills one of two endpoint table
// banks while the emitter reads out the other, so a new buffer streams in
// while the previous run drains. in_stall rises only when a run ends while
// the bank it needs still holds an earlier run being read out.
// The summary passes through the queue, a staging register and the output
// register; endpoint records follow one per cycle from the table memory.
// Reset: synchronous, active low; match registers return to 8/6/80, parse
// state and queues clear. No clearing pass is needed on the table.
// A stalled receiver holds the output register; the emitter and then the
// queue back up, and finally in_stall stops the bytes.
module usb_config_descriptor_parser_top import ucdp_pkg::*; #(
  parameter int MAX_ENDPOINTS = MAX_ENDPOINTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  q_status_t q_status;
  logic      push, pop;
  run_t      push_data, head;
  ep_wr_t    ep_wr;
  burst_wr_t burst_wr;

  // configuration registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  // front: parse bytes, fill the table, hand off each finished run
  ucdp_front #(
    .MAX_ENDPOINTS(MAX_ENDPOINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data),
    .ep_wr     (ep_wr),
    .burst_wr  (burst_wr)
  );

  // hold up to two finished runs, one per table bank
  ucdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // back: emit summary and endpoint records of the oldest run
  ucdp_back #(
    .MAX_ENDPOINTS(MAX_ENDPOINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ep_wr      (ep_wr),
    .burst_wr   (burst_wr),
    .head       (head),
    .q_nonempty (q_status.nonempty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ----- design/ucdp_front.sv -----
`timescale 1ns / 1ps

module ucdp_front import ucdp_pkg::*; #(
  parameter int MAX_ENDPOINTS = MAX_ENDPOINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  logic      cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  q_status_t q_status,
  output logic      push,
  output run_t      push_data,
  output ep_wr_t    ep_wr,
  output burst_wr_t burst_wr
);

  localparam int CW = $clog2(MAX_ENDPOINTS + 1);

  logic [7:0]    want_class_r, want_subclass_r, want_protocol_r;
  logic [3:0]    total_r, total_nxt;
  logic [7:0]    off_r, off_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    dtype_r, dtype_nxt;
  logic [7:0]    cap_r [8];
  logic [7:0]    cap_nxt [8];
  logic          stopped_r, stopped_nxt;
  logic          matched_r, matched_nxt;
  logic          rev_r, rev_nxt;
  iface_t        iface_r, iface_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          bank_r, bank_nxt;
  logic          acc;

  assign in_stall = q_status.busy[bank_r];
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_class_r    <= WANT_CLASS_RST;
      want_subclass_r <= WANT_SUBCLASS_RST;
      want_protocol_r <= WANT_PROTOCOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WANT_CLASS:    want_class_r    <= cfg_data;
        CFG_WANT_SUBCLASS: want_subclass_r <= cfg_data;
        CFG_WANT_PROTOCOL: want_protocol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [7:0] off_cur;
    logic [7:0] off_inc;
    logic [7:0] typ;
    logic       go;
    logic       done;
    logic       m;

    b           = in_item.data_byte;
    off_cur     = off_r;
    off_inc     = '0;
    typ         = dtype_r;
    go          = 1'b0;
    done        = 1'b0;
    m           = 1'b0;
    total_nxt   = total_r;
    off_nxt     = off_r;
    len_nxt     = len_r;
    dtype_nxt   = dtype_r;
    cap_nxt     = cap_r;
    stopped_nxt = stopped_r;
    matched_nxt = matched_r;
    rev_nxt     = rev_r;
    iface_nxt   = iface_r;
    cnt_nxt     = cnt_r;
    bank_nxt    = bank_r;
    ep_wr       = '0;
    burst_wr    = '0;
    push        = 1'b0;
    push_data   = '0;

    if (acc) begin
      if (total_r != '1) begin
        total_nxt = total_r + 4'd1;
      end
      if (!stopped_r) begin
        go = 1'b1;
        // one-byte descriptor: this byte is its type and the next length
        if (off_r == 8'd1 && len_r == 8'd1) begin
          dtype_nxt = b;
          off_cur   = '0;
          off_nxt   = '0;
          if (matched_r && b == TYPE_INTERFACE) begin
            stopped_nxt = 1'b1;
            go          = 1'b0;
          end
        end
        if (go) begin
          if (off_cur == 8'd0) begin
            if (b == 8'd0) begin
              stopped_nxt = 1'b1;
            end else begin
              len_nxt    = b;
              cap_nxt[0] = b;
              off_nxt    = 8'd1;
            end
          end else begin
            if (off_cur < 8'd8) begin
              cap_nxt[off_cur[2:0]] = b;
            end
            if (off_cur == 8'd1) begin
              dtype_nxt = b;
            end
            typ     = dtype_nxt;
            off_inc = off_cur + 8'd1;
            off_nxt = off_inc;
            if (off_inc == len_r) begin
              done    = 1'b1;
              off_nxt = '0;
            end
          end
        end
      end
    end

    // act on a completed descriptor
    if (done) begin
      priority if (typ == TYPE_INTERFACE && len_r >= LEN_INTERFACE) begin
        m = cap_nxt[3] == 8'd0 && cap_nxt[5] == want_class_r &&
            cap_nxt[6] == want_subclass_r && cap_nxt[7] == want_protocol_r;
        matched_nxt = m;
        if (m) begin
          iface_nxt = '{proto: cap_nxt[7], sub: cap_nxt[6], cls: cap_nxt[5],
                        num: cap_nxt[2]};
          cnt_nxt   = '0;
        end
        rev_nxt = 1'b0;
      end else if (matched_r && typ == TYPE_ENDPOINT && len_r >= LEN_ENDPOINT) begin
        if (cnt_r < CW'(MAX_ENDPOINTS)) begin
          ep_wr.en            = 1'b1;
          ep_wr.bank          = bank_r;
          ep_wr.idx           = IDX_W'(cnt_r);
          ep_wr.data.addr     = cap_nxt[2];
          ep_wr.data.attr     = cap_nxt[3];
          ep_wr.data.interval = cap_nxt[6];
          ep_wr.data.mps      = {cap_nxt[5][MPS_W-9:0], cap_nxt[4]};
          burst_wr.en         = 1'b1;
          burst_wr.bank       = bank_r;
          burst_wr.idx        = IDX_W'(cnt_r);
          burst_wr.burst      = '0;
          cnt_nxt             = cnt_r + CW'(1);
          rev_nxt             = 1'b1;
        end
      end else if (matched_r && rev_r && typ == TYPE_SS_COMPANION &&
                   len_r >= LEN_COMPANION) begin
        if (cnt_r != '0) begin
          burst_wr.en    = 1'b1;
          burst_wr.bank  = bank_r;
          burst_wr.idx   = IDX_W'(cnt_r - CW'(1));
          burst_wr.burst = cap_nxt[2];
        end
      end else if (matched_r && typ == TYPE_INTERFACE) begin
        stopped_nxt = 1'b1;
      end else begin
      end
    end

    // end of run: hand the summary off, flip the table bank, clear the parse
    if (acc && in_item.final_byte) begin
      push           = 1'b1;
      push_data.bank = bank_r;
      if (total_nxt >= MIN_RUN_BYTES) begin
        push_data.n     = CNT_W'(cnt_nxt);
        push_data.found = matched_nxt && cnt_nxt != '0;
        push_data.iface = iface_nxt;
      end
      total_nxt   = '0;
      off_nxt     = '0;
      len_nxt     = '0;
      dtype_nxt   = '0;
      stopped_nxt = 1'b0;
      matched_nxt = 1'b0;
      rev_nxt     = 1'b0;
      iface_nxt   = '0;
      cnt_nxt     = '0;
      bank_nxt    = ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      off_r     <= '0;
      len_r     <= '0;
      dtype_r   <= '0;
      stopped_r <= 1'b0;
      matched_r <= 1'b0;
      rev_r     <= 1'b0;
      iface_r   <= '0;
      cnt_r     <= '0;
      bank_r    <= 1'b0;
    end else begin
      total_r   <= total_nxt;
      off_r     <= off_nxt;
      len_r     <= len_nxt;
      dtype_r   <= dtype_nxt;
      stopped_r <= stopped_nxt;
      matched_r <= matched_nxt;
      rev_r     <= rev_nxt;
      iface_r   <= iface_nxt;
      cnt_r     <= cnt_nxt;
      bank_r    <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r <= cap_nxt;
  end

endmodule

// ----- design/ucdp_queue.sv -----
`timescale 1ns / 1ps

module ucdp_queue import ucdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  run_t      push_data,
  input  logic      pop,
  output run_t      head,
  output q_status_t q_status
);

  run_t       slot_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] count_r;

  assign head = slot_r[rd_ptr_r];

  always_comb begin
    logic vld;
    q_status.nonempty = count_r != 2'd0;
    q_status.busy     = 2'b00;
    for (int i = 0; i < 2; i++) begin
      vld = (count_r == 2'd2) || (count_r == 2'd1 && rd_ptr_r == 1'(i));
      if (vld) begin
        q_status.busy[slot_r[i].bank] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/ucdp_back.sv -----
`timescale 1ns / 1ps

module ucdp_back import ucdp_pkg::*; #(
  parameter int MAX_ENDPOINTS = MAX_ENDPOINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ep_wr_t    ep_wr,
  input  burst_wr_t burst_wr,
  input  run_t      head,
  input  logic      q_nonempty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

  ep_data_t   ep_mem    [2][MAX_ENDPOINTS];
  logic [7:0] burst_mem [2][MAX_ENDPOINTS];
  ep_data_t   rd_ep_r;
  logic [7:0] rd_burst_r;

  bk_state_t  state_r, state_nxt;
  logic [IW-1:0] k_r, k_nxt;

  logic       a_valid_r, a_valid_nxt;
  logic       a_kind_r, a_last_r;
  run_t       a_run_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic       a_move, a_take, gen;
  logic       a_load, load_kind, load_last, rd_en, ep_last;

  assign a_move  = a_valid_r && (!out_valid_r || !out_stall);
  assign a_take  = !a_valid_r || a_move;
  assign gen     = a_take && q_nonempty;
  assign ep_last = (CNT_W'(k_r) + CNT_W'(1)) == head.n;

  // table banks: the parser fills one while the other is read out
  always_ff @(posedge clk) begin
    if (ep_wr.en) begin
      ep_mem[ep_wr.bank][ep_wr.idx[IW-1:0]] <= ep_wr.data;
    end
    if (burst_wr.en) begin
      burst_mem[burst_wr.bank][burst_wr.idx[IW-1:0]] <= burst_wr.burst;
    end
    if (rd_en) begin
      rd_ep_r    <= ep_mem[head.bank][k_r];
      rd_burst_r <= burst_mem[head.bank][k_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_SUMMARY: begin
        if (gen && head.n != '0) begin
          state_nxt = BK_ENDPOINT;
        end
      end
      BK_ENDPOINT: begin
        if (gen && ep_last) begin
          state_nxt = BK_SUMMARY;
        end
      end
      default: state_nxt = BK_SUMMARY;
    endcase
  end

  always_comb begin
    a_load    = 1'b0;
    load_kind = RECORD_SUMMARY;
    load_last = 1'b0;
    rd_en     = 1'b0;
    pop       = 1'b0;
    k_nxt     = k_r;
    unique case (state_r)
      BK_SUMMARY: begin
        if (gen) begin
          a_load    = 1'b1;
          load_last = head.n == '0;
          pop       = head.n == '0;
          k_nxt     = '0;
        end
      end
      BK_ENDPOINT: begin
        if (gen) begin
          a_load    = 1'b1;
          load_kind = RECORD_ENDPOINT;
          load_last = ep_last;
          rd_en     = 1'b1;
          pop       = ep_last;
          k_nxt     = ep_last ? '0 : k_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    a_valid_nxt = a_load ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
    if (a_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_item_nxt                = out_item_r;
    if (a_move) begin
      out_item_nxt.record_kind    = a_kind_r;
      out_item_nxt.found          = a_run_r.found;
      out_item_nxt.endpoint_total = TOT_W'(a_run_r.n);
      out_item_nxt.last_record    = a_last_r;
      if (a_kind_r == RECORD_SUMMARY) begin
        out_item_nxt.number_or_address    = a_run_r.iface.num;
        out_item_nxt.class_or_attributes  = a_run_r.iface.cls;
        out_item_nxt.subclass_or_interval = a_run_r.iface.sub;
        out_item_nxt.iface_protocol       = a_run_r.iface.proto;
        out_item_nxt.max_packet           = '0;
        out_item_nxt.max_burst            = '0;
      end else begin
        out_item_nxt.number_or_address    = rd_ep_r.addr;
        out_item_nxt.class_or_attributes  = rd_ep_r.attr;
        out_item_nxt.subclass_or_interval = rd_ep_r.interval;
        out_item_nxt.iface_protocol       = '0;
        out_item_nxt.max_packet           = rd_ep_r.mps;
        out_item_nxt.max_burst            = rd_burst_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SUMMARY;
      k_r         <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_kind_r <= load_kind;
      a_last_r <= load_last;
      a_run_r  <= head;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
